/* hw/rtl/dtms_pkg.sv */
// ----------------------------------------------------------------------------
// dtms_pkg
// Shared types and constants of the dual timer with match slots: item
// payloads, function and register offset codes, control word fields and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package dtms_pkg;

  localparam int FUNC_W   = 2;
  localparam int OFF_W    = 4;
  localparam int DATA_W   = 16;
  localparam int TICK_W   = 10;
  localparam int MODE_W   = 5;
  localparam int IRQ_W    = 6;
  localparam int NUM_SLOT = 6;

  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [OFF_W-1:0]  off_t;
  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [IRQ_W-1:0]  irq_vec_t;

  // function codes
  localparam func_t FUNC_TICK  = 2'd0;
  localparam func_t FUNC_READ  = 2'd1;
  localparam func_t FUNC_WRITE = 2'd2;

  // register offsets
  localparam off_t OFF_CNT0  = 4'd0;
  localparam off_t OFF_DIV0  = 4'd1;
  localparam off_t OFF_CTL0  = 4'd2;
  localparam off_t OFF_CNT1  = 4'd3;
  localparam off_t OFF_DIV1  = 4'd4;
  localparam off_t OFF_CTL1  = 4'd5;
  localparam off_t OFF_SLOT0 = 4'd6;
  localparam off_t OFF_SLOT5 = 4'd11;
  localparam off_t OFF_NOP   = 4'd12;
  localparam off_t OFF_STAT  = 4'd13;
  localparam off_t OFF_MASK  = 4'd14;
  localparam off_t OFF_UNDEC = 4'd15;

  // control word
  localparam mode_t MODE_RESET = 5'h10;
  localparam int    CTL_STOP_BIT = 4;
  localparam int    CTL_UP_BIT   = 3;
  localparam logic [2:0] SEL_HOLD = 3'd0;
  localparam logic [2:0] SEL_NONE = 3'd7;

  typedef struct packed {
    func_t                   func;
    off_t                    reg_offset;
    logic [DATA_W-1:0]       write_data;
    logic [TICK_W-1:0]       tick_count;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq;
    logic              bad_access;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic write_reg;
    logic load_acc;
    logic step;
    logic store_acc;
    logic emit;
    logic sel;
  } dtms_cmd_t;

  typedef struct packed {
    logic tick_item;
    logic cnt_stopped;
    logic acc_over;
    logic out_busy;
  } dtms_stat_t;

endpackage

/* hw/rtl/dtms_if.sv */
// ----------------------------------------------------------------------------
// dtms_if
// Valid/ready channels of the timer block: one for input items, one for
// result items.
// ----------------------------------------------------------------------------
interface dtms_in_if;
  logic               valid;
  logic               ready;
  dtms_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dtms_out_if;
  logic                valid;
  logic                ready;
  dtms_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/dtms_ctrl.sv */
// ----------------------------------------------------------------------------
// dtms_ctrl
// Sequencer of the timer block: takes an item, runs the register access or
// the divider loop of each running counter, then hands over the result.
// ----------------------------------------------------------------------------
module dtms_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dtms_pkg::dtms_stat_t stat,
  output dtms_pkg::dtms_cmd_t  cmd
);
  import dtms_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_LOAD     = 3'd2;
  localparam logic [2:0] S_STEP     = 3'd3;
  localparam logic [2:0] S_DONE     = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       cur_r, cur_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    cmd       = '0;
    cmd.sel   = cur_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cur_nxt = 1'b0;
        if (stat.tick_item) begin
          state_nxt = S_LOAD;
        end else begin
          cmd.write_reg = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_LOAD: begin
        if (stat.cnt_stopped) begin
          if (cur_r) begin
            state_nxt = S_DONE;
          end else begin
            cur_nxt = 1'b1;
          end
        end else begin
          cmd.load_acc = 1'b1;
          state_nxt    = S_STEP;
        end
      end
      S_STEP: begin
        if (stat.acc_over) begin
          cmd.step = 1'b1;
        end else begin
          cmd.store_acc = 1'b1;
          if (cur_r) begin
            state_nxt = S_DONE;
          end else begin
            cur_nxt   = 1'b1;
            state_nxt = S_LOAD;
          end
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/dtms_dp.sv */
// ----------------------------------------------------------------------------
// dtms_dp
// Datapath of the timer block: register file, prescale accumulator, the
// single counter step unit, match compare and the result register.
// ----------------------------------------------------------------------------
module dtms_dp #(
  parameter int COUNTER_WIDTH      = 16,
  parameter int MAX_TICKS_PER_ITEM = 1023
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dtms_pkg::in_item_t    in_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output dtms_pkg::out_item_t   out_data,
  input  dtms_pkg::dtms_cmd_t   cmd,
  output dtms_pkg::dtms_stat_t  stat
);
  import dtms_pkg::*;

  localparam int CW     = COUNTER_WIDTH;
  localparam int TK_W   = $clog2(MAX_TICKS_PER_ITEM + 1);
  localparam int ACC_W  = ((CW > TK_W) ? CW : TK_W) + 1;

  typedef logic [CW-1:0]    cnt_t;
  typedef logic [ACC_W-1:0] acc_t;

  in_item_t  item_r;
  cnt_t      count_r  [2];
  cnt_t      reload_r [2];
  cnt_t      limit_r  [2];
  mode_t     mode_r   [2];
  acc_t      pre_r    [2];
  cnt_t      slot_r   [NUM_SLOT];
  irq_vec_t  pend_r;
  irq_vec_t  ena_r;
  acc_t      acc_r;
  logic      out_valid_r;
  out_item_t out_data_r;

  acc_t      ticks_sat;
  cnt_t      wr_val;
  cnt_t      cur_cnt;
  mode_t     cur_mode;
  logic [2:0] cur_sel;
  cnt_t      sel_slot;
  logic      sel_hit;
  cnt_t      step_val;
  irq_vec_t  hit_vec;
  logic [DATA_W-1:0] rd_val;
  logic      bad;
  logic [2:0] wr_slot;

  assign ticks_sat = (32'(item_r.tick_count) > 32'(MAX_TICKS_PER_ITEM)) ?
                     ACC_W'(MAX_TICKS_PER_ITEM) : ACC_W'(item_r.tick_count);
  assign wr_val    = CW'(item_r.write_data);
  assign wr_slot   = 3'(item_r.reg_offset - OFF_SLOT0);

  // step unit for the selected counter
  assign cur_cnt  = count_r[cmd.sel];
  assign cur_mode = mode_r[cmd.sel];
  assign cur_sel  = cur_mode[2:0];

  always_comb begin
    sel_hit  = 1'b0;
    sel_slot = '0;
    unique case (cur_sel)
      3'd1: sel_slot = slot_r[0];
      3'd2: sel_slot = slot_r[1];
      3'd3: sel_slot = slot_r[2];
      3'd4: sel_slot = slot_r[3];
      3'd5: sel_slot = slot_r[4];
      3'd6: sel_slot = slot_r[5];
      default: sel_slot = '0;
    endcase
    sel_hit = (cur_sel != SEL_HOLD) && (cur_sel != SEL_NONE) && (cur_cnt == sel_slot);
  end

  always_comb begin
    priority if ((cur_sel == SEL_HOLD) && (cur_cnt == '0)) begin
      step_val = cur_cnt;
    end else if (sel_hit) begin
      step_val = reload_r[cmd.sel];
    end else if (cur_mode[CTL_UP_BIT]) begin
      step_val = cur_cnt + 1'b1;
    end else begin
      step_val = cur_cnt - 1'b1;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_SLOT; k++) begin
      hit_vec[k] = (step_val == slot_r[k]);
    end
  end

  assign stat.tick_item   = (item_r.func == FUNC_TICK);
  assign stat.cnt_stopped = cur_mode[CTL_STOP_BIT];
  assign stat.acc_over    = (acc_r > ACC_W'(limit_r[cmd.sel]));
  assign stat.out_busy    = out_valid_r && !out_ready;

  // item capture and accumulator
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.load_acc) begin
      acc_r <= pre_r[cmd.sel] + ticks_sat;
    end else if (cmd.step) begin
      acc_r <= acc_r - (ACC_W'(limit_r[cmd.sel]) + 1'b1);
    end
  end

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < 2; n++) begin
        count_r[n]  <= '0;
        reload_r[n] <= '0;
        limit_r[n]  <= '0;
        mode_r[n]   <= MODE_RESET;
        pre_r[n]    <= '0;
      end
      for (int k = 0; k < NUM_SLOT; k++) begin
        slot_r[k] <= '0;
      end
      pend_r <= '0;
      ena_r  <= '0;
    end else if (cmd.step) begin
      count_r[cmd.sel] <= step_val;
      if (!cmd.sel) begin
        pend_r <= pend_r | hit_vec;
      end
    end else if (cmd.store_acc) begin
      pre_r[cmd.sel] <= acc_r;
    end else if (cmd.write_reg && (item_r.func == FUNC_WRITE)) begin
      unique case (item_r.reg_offset)
        OFF_CNT0: begin
          count_r[0]  <= wr_val;
          reload_r[0] <= wr_val;
        end
        OFF_DIV0: limit_r[0] <= wr_val;
        OFF_CTL0: mode_r[0]  <= item_r.write_data[MODE_W-1:0];
        OFF_CNT1: begin
          count_r[1]  <= wr_val;
          reload_r[1] <= wr_val;
        end
        OFF_DIV1: limit_r[1] <= wr_val;
        OFF_CTL1: mode_r[1]  <= item_r.write_data[MODE_W-1:0];
        OFF_STAT: pend_r     <= pend_r & ~item_r.write_data[IRQ_W-1:0];
        OFF_MASK: ena_r      <= item_r.write_data[IRQ_W-1:0];
        OFF_NOP, OFF_UNDEC: begin
        end
        default: slot_r[wr_slot] <= wr_val;
      endcase
    end
  end

  // read mux
  always_comb begin
    rd_val = '0;
    bad    = 1'b0;
    if (item_r.func == FUNC_READ) begin
      unique case (item_r.reg_offset)
        OFF_CNT0:  rd_val = DATA_W'(count_r[0]);
        OFF_DIV0:  rd_val = DATA_W'(limit_r[0]);
        OFF_CTL0:  rd_val = DATA_W'(mode_r[0]);
        OFF_CNT1:  rd_val = DATA_W'(count_r[1]);
        OFF_DIV1:  rd_val = DATA_W'(limit_r[1]);
        OFF_CTL1:  rd_val = DATA_W'(mode_r[1]);
        OFF_STAT:  rd_val = DATA_W'(pend_r);
        OFF_MASK:  rd_val = DATA_W'(ena_r);
        OFF_NOP, OFF_UNDEC: bad = 1'b1;
        default:   rd_val = DATA_W'(slot_r[wr_slot]);
      endcase
    end else if (item_r.func == FUNC_WRITE) begin
      bad = (item_r.reg_offset == OFF_UNDEC);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.read_data  <= rd_val;
      out_data_r.irq        <= |(pend_r & ena_r);
      out_data_r.bad_access <= bad;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/dual_timer_with_match_slots.sv */
// ----------------------------------------------------------------------------
// dual_timer_with_match_slots
// Two divided counters sharing six compare slots, which flag counter 0 hits,
// interrupt status and mask, driven by tick, read and write items.
// ----------------------------------------------------------------------------
// One item is taken at a time and each gives one result. A read, a write or
// an unused function code skips the divider loop. A tick item runs the
// divider loop of each counter that is running, one divided step at a time,
// where the step count is floor((prescale + ticks) / (divider + 1)) and the
// ticks are capped at MAX_TICKS_PER_ITEM; the single step unit does one
// counter step per cycle. After a divider is lowered below its prescale
// count the next tick also works off the steps held in that prescale count.
// The next item is taken while a result still waits in the output register.
module dual_timer_with_match_slots #(
  parameter int COUNTER_WIDTH      = 16,
  parameter int MAX_TICKS_PER_ITEM = 1023
) (
  input  logic              clk,
  input  logic              rst_n,
  dtms_in_if.sink           in_ch,
  dtms_out_if.source        out_ch
);
  import dtms_pkg::*;

  dtms_cmd_t  cmd;
  dtms_stat_t stat;
  logic       in_rdy;

  dtms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_rdy),
    .stat     (stat),
    .cmd      (cmd)
  );

  dtms_dp #(
    .COUNTER_WIDTH      (COUNTER_WIDTH),
    .MAX_TICKS_PER_ITEM (MAX_TICKS_PER_ITEM)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_ch.data),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.data),
    .cmd       (cmd),
    .stat      (stat)
  );

  assign in_ch.ready = in_rdy;

endmodule
